>>> rtl/core/rlp_item_encoder_macros.svh
`ifndef RLP_ITEM_ENCODER_MACROS_SVH
`define RLP_ITEM_ENCODER_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define RLP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define RLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rlp_pkg.sv
`default_nettype none

package rlp_pkg;

    localparam int MAX_LEN_BYTES = 4;
    // the length field is 32 bits, so never more than four length bytes
    localparam int LEN_BYTES     = (MAX_LEN_BYTES < 4) ? MAX_LEN_BYTES : 4;
    localparam int DESC_BYTES    = LEN_BYTES + 2;
    localparam int NW            = $clog2(LEN_BYTES + 1);
    localparam int CW            = $clog2(DESC_BYTES + 1);

    localparam logic [31:0] LEN_LIMIT = (LEN_BYTES >= 4) ? 32'hffff_ffff :
                                        32'((64'd1 << (8 * LEN_BYTES)) - 64'd1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int S_TDATA_W = 40;

    localparam logic CMD_STRING = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    localparam logic [7:0]  HDR_STR_SHORT  = 8'h80;
    localparam logic [7:0]  HDR_STR_LONG   = 8'hb7;
    localparam logic [7:0]  HDR_LIST_SHORT = 8'hc0;
    localparam logic [7:0]  HDR_LIST_LONG  = 8'hf7;
    localparam logic [31:0] SHORT_MAX      = 32'd55;
    localparam logic [7:0]  SINGLE_LIMIT   = 8'h80;

    // bytes[0] goes out first
    typedef struct packed {
        logic [DESC_BYTES-1:0][7:0] bytes;
        logic [CW-1:0]              cnt;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rlp_front.sv
`default_nettype none

module rlp_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic [rlp_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          push_ready,
    output logic                               push_valid,
    output rlp_pkg::desc_t                     push_desc
);
    import rlp_pkg::*;

    logic [31:0]                rem_reg, rem_next;
    logic [31:0]                s_len, len_c, len_al;
    logic [7:0]                 s_db;
    logic [NW-1:0]              n;
    logic                       is_short;
    logic                       item_open;
    logic                       opens;
    logic [DESC_BYTES-1:0][7:0] long_bytes;
    logic                       accept;

    assign s_len      = s_tdata[31:0];
    assign s_db       = s_tdata[39:32];
    assign item_open  = rem_reg != 32'd0;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // length bytes, big-endian, without leading zeros
    always_comb begin
        len_c = (s_len > LEN_LIMIT) ? LEN_LIMIT : s_len;
        n     = NW'(1);
        for (int i = 1; i < LEN_BYTES; i++) begin
            if (len_c[8*i +: 8] != 8'h00) begin
                n = NW'(i + 1);
            end
        end
        len_al     = len_c << (8 * (LEN_BYTES - int'(n)));
        long_bytes = '0;
        for (int k = 0; k < LEN_BYTES; k++) begin
            if (NW'(k) < n) begin
                long_bytes[1 + k] = len_al[8*(LEN_BYTES-1-k) +: 8];
            end
        end
        is_short = len_c <= SHORT_MAX;
    end

    always_comb begin
        push_desc       = '0;
        push_desc.cnt   = CW'(1);
        opens           = 1'b0;
        if (item_open) begin
            push_desc.bytes[0] = s_db;
        end else if (s_tuser == CMD_LIST) begin
            if (is_short) begin
                push_desc.bytes[0] = HDR_LIST_SHORT + len_c[7:0];
            end else begin
                push_desc.bytes    = long_bytes;
                push_desc.bytes[0] = HDR_LIST_LONG + 8'(n);
                push_desc.cnt      = CW'(n) + CW'(1);
            end
        end else begin
            if (len_c == 32'd0) begin
                push_desc.bytes[0] = HDR_STR_SHORT;
            end else if (len_c == 32'd1 && s_db == 8'h00) begin
                push_desc.bytes[0] = HDR_STR_SHORT;
            end else if (len_c == 32'd1 && s_db < SINGLE_LIMIT) begin
                push_desc.bytes[0] = s_db;
            end else begin
                opens = 1'b1;
                if (is_short) begin
                    push_desc.bytes[0] = HDR_STR_SHORT + len_c[7:0];
                    push_desc.bytes[1] = s_db;
                    push_desc.cnt      = CW'(2);
                end else begin
                    push_desc.bytes    = long_bytes;
                    push_desc.bytes[0] = HDR_STR_LONG + 8'(n);
                    for (int p = 2; p < DESC_BYTES; p++) begin
                        if (p == int'(n) + 1) begin
                            push_desc.bytes[p] = s_db;
                        end
                    end
                    push_desc.cnt = CW'(n) + CW'(2);
                end
            end
        end
    end

    always_comb begin
        rem_next = rem_reg;
        if (accept) begin
            if (item_open) begin
                rem_next = rem_reg - 32'd1;
            end else if (opens) begin
                rem_next = len_c - 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlp_queue.sv
`default_nettype none

module rlp_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    input  wire rlp_pkg::desc_t push_desc,
    output logic                push_ready,
    output logic                pop_valid,
    output rlp_pkg::desc_t      pop_desc,
    input  wire logic           pop,
    output rlp_pkg::q_stat_t    stat
);
    import rlp_pkg::*;

    desc_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = count_reg == Q_CW'(Q_DEPTH);
    assign stat.empty = count_reg == '0;
    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlp_back.sv
`default_nettype none

module rlp_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire rlp_pkg::desc_t q_desc,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import rlp_pkg::*;

    logic [DESC_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       valid_reg, valid_next;

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = cnt_reg == CW'(1);
    // take the next descriptor when idle or when the final beat leaves
    assign q_pop    = q_valid && (!valid_reg || (m_tready && m_tlast));

    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            bytes_next = q_desc.bytes;
            cnt_next   = q_desc.cnt;
            valid_next = 1'b1;
        end else if (valid_reg && m_tready) begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - CW'(1);
            valid_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        cnt_reg   <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlp_item_encoder.sv
// RLP encoder for byte strings and list headers.
// Slave channel: one beat per input. A string item opens with its length in
// the beat that carries its first payload byte; the following beats carry the
// remaining payload bytes. tuser set on an opening beat asks for a list header.
// Master channel: one encoded byte per beat; tlast marks the final byte that
// a given input beat produced.
// Each input beat is registered in the descriptor queue, then in the serializer.
// Throughput: one output byte per cycle while m_tready is high. Payload beats
// and single-byte items run at one beat per cycle; an item opening with a header
// emits up to six bytes, one per cycle, set by the back-end byte serializer.
// A four-entry descriptor queue sits between classifier and serializer, so
// input keeps flowing while a header drains, until the queue fills.
// When m_tready is low the current byte holds, the queue fills and then
// s_tready drops. Reset empties the queue, drops m_tvalid and closes any
// open item; the block accepts input in the first cycle after reset.
`default_nettype none

module rlp_item_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rlp_pkg::S_TDATA_W-1:0] s_tdata,  // item_len[31:0], data_byte[39:32]
    input  wire logic                          s_tuser,  // cmd
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // out_byte[7:0]
    output logic                               m_tlast
);
    import rlp_pkg::*;

`include "rlp_item_encoder_macros.svh"

    logic    push_valid, push_ready;
    desc_t   push_desc;
    logic    q_valid, q_pop;
    desc_t   q_desc;
    q_stat_t q_stat;

    assign s_tready = push_ready;

    rlp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_desc  (push_desc)
    );

    rlp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_desc   (q_desc),
        .pop        (q_pop),
        .stat       (q_stat)
    );

    rlp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_desc   (q_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `RLP_ASSERT_ALWAYS(a_q_full_empty, !(q_stat.full && q_stat.empty), "queue full and empty")
    `RLP_ASSERT_NEXT(a_push_lands, s_tvalid && s_tready && q_stat.empty, !q_stat.empty, "beat lost")
    `RLP_ASSERT_NEXT(a_drain_idle, m_tvalid && m_tready && m_tlast && q_stat.empty, !m_tvalid, "phantom beat")

endmodule

`default_nettype wire
